>>> rtl/core/rmr_pkg.sv
// ----------------------------------------------------------------------------
// rmr_pkg
// shared widths and types for the rational multiply and reduce block
// ----------------------------------------------------------------------------
`default_nettype none

package rmr_pkg;

  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int unsigned OUT_WIDTH  = 32;
  localparam int unsigned IN_BYTES   = (4 * DATA_WIDTH + 7) / 8;
  localparam int unsigned OUT_BYTES  = (2 * OUT_WIDTH + 7) / 8;
  localparam int unsigned CNT_WIDTH  = $clog2(PROD_WIDTH + 1);
  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic                           zero;
    logic                           p_neg;
    logic                           q_neg;
    logic [PROD_WIDTH-1:0]          p_mag;
    logic [PROD_WIDTH-1:0]          q_mag;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVP,
    ST_DIVQ,
    ST_OUT
  } back_state_e;

endpackage

`default_nettype wire

>>> rtl/core/rmr_front.sv
// ----------------------------------------------------------------------------
// rmr_front
// forms both products, their magnitudes and signs, and queues the job
// ----------------------------------------------------------------------------
`default_nettype none

module rmr_front import rmr_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [DATA_WIDTH-1:0]   num_a_i,
  input  wire logic [DATA_WIDTH-1:0]   den_a_i,
  input  wire logic [DATA_WIDTH-1:0]   num_b_i,
  input  wire logic [DATA_WIDTH-1:0]   den_b_i,
  output logic                         job_valid_o,
  input  wire logic                    job_ready_i,
  output job_t                         job_o
);

  logic signed [PROD_WIDTH-1:0] p_s, q_s;
  job_t                         new_job;
  job_t                         fifo_q [FIFO_DEPTH];
  logic                         rd_ptr_q, wr_ptr_q;
  logic [1:0]                   cnt_q;
  logic                         push, pop;

  always_comb begin
    p_s = $signed(num_a_i) * $signed(num_b_i);
    q_s = $signed(den_a_i) * $signed(den_b_i);
    new_job.p_neg = p_s[PROD_WIDTH-1];
    new_job.q_neg = q_s[PROD_WIDTH-1];
    new_job.p_mag = p_s[PROD_WIDTH-1] ? PROD_WIDTH'(-p_s) : PROD_WIDTH'(p_s);
    new_job.q_mag = q_s[PROD_WIDTH-1] ? PROD_WIDTH'(-q_s) : PROD_WIDTH'(q_s);
    new_job.zero  = (p_s == '0) && (q_s == '0);
  end

  assign in_ready_o  = (cnt_q != 2'(FIFO_DEPTH));
  assign job_valid_o = (cnt_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(FIFO_DEPTH))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue count lost a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("pointers differ when empty");

endmodule

`default_nettype wire

>>> rtl/core/rmr_back.sv
// ----------------------------------------------------------------------------
// rmr_back
// euclid gcd by restoring remainder steps, then two restoring divisions
// ----------------------------------------------------------------------------
`default_nettype none

module rmr_back import rmr_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    job_valid_i,
  output logic                         job_ready_o,
  input  job_t                         job_i,
  output logic                         res_valid_o,
  input  wire logic                    res_ready_i,
  output logic [OUT_WIDTH-1:0]         num_out_o,
  output logic [OUT_WIDTH-1:0]         den_out_o,
  output logic                         zero_error_o
);

  localparam int unsigned W = PROD_WIDTH;

  back_state_e           state_q, state_d;
  job_t                  job_q;
  logic [W-1:0]          a_q, a_d, b_q, b_d;
  logic [W-1:0]          rem_q, rem_d, quo_q, quo_d, dvd_q, dvd_d;
  logic [CNT_WIDTH-1:0]  cnt_q, cnt_d;
  logic [W-1:0]          np_q, np_d;
  logic [OUT_WIDTH-1:0]  nout_q, nout_d, dout_q, dout_d;
  logic                  zerr_q, zerr_d;
  logic                  load;
  logic [W:0]            trial;
  logic [W-1:0]          rem_sh;
  logic [W-1:0]          divisor;
  logic [W-1:0]          np_signed, nq_signed;

  assign job_ready_o  = (state_q == ST_IDLE);
  assign load         = job_valid_i && job_ready_o;
  assign res_valid_o  = (state_q == ST_OUT);
  assign num_out_o    = nout_q;
  assign den_out_o    = dout_q;
  assign zero_error_o = zerr_q;

  // one restoring step: shift in next dividend bit, subtract divisor
  assign divisor = (state_q == ST_GCD) ? b_q : a_q;
  assign rem_sh  = {rem_q[W-2:0], dvd_q[W-1]};
  assign trial   = {rem_q, dvd_q[W-1]} - {1'b0, divisor};
  assign np_signed = job_q.p_neg ? W'(-np_q) : np_q;
  assign nq_signed = job_q.q_neg ? W'(-{quo_q[W-2:0], ~trial[W]}) :
                     {quo_q[W-2:0], ~trial[W]};

  always_comb begin
    state_d = state_q;
    a_d = a_q; b_d = b_q; rem_d = rem_q; quo_d = quo_q; dvd_d = dvd_q;
    cnt_d = cnt_q; np_d = np_q; nout_d = nout_q; dout_d = dout_q; zerr_d = zerr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load) begin
          a_d   = job_i.p_mag;
          b_d   = job_i.q_mag;
          rem_d = '0;
          dvd_d = job_i.p_mag;
          cnt_d = '0;
          if (job_i.zero) begin
            nout_d = '0; dout_d = '0; zerr_d = 1'b1;
            state_d = ST_OUT;
          end else if (job_i.q_mag == '0) begin
            state_d = ST_DIVP;
          end else begin
            state_d = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        rem_d = trial[W] ? rem_sh : trial[W-1:0];
        dvd_d = {dvd_q[W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_WIDTH'(W - 1)) begin
          cnt_d = '0;
          dvd_d = b_q;
          rem_d = '0;
          a_d   = b_q;
          if ((trial[W] ? rem_sh : trial[W-1:0]) == '0) begin
            dvd_d = job_q.p_mag;
            state_d = ST_DIVP;
          end else begin
            b_d = trial[W] ? rem_sh : trial[W-1:0];
          end
        end
      end
      ST_DIVP, ST_DIVQ: begin
        rem_d = trial[W] ? rem_sh : trial[W-1:0];
        quo_d = {quo_q[W-2:0], ~trial[W]};
        dvd_d = {dvd_q[W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_WIDTH'(W - 1)) begin
          cnt_d = '0;
          rem_d = '0;
          if (state_q == ST_DIVP) begin
            np_d    = {quo_q[W-2:0], ~trial[W]};
            dvd_d   = job_q.q_mag;
            state_d = ST_DIVQ;
          end else begin
            nout_d  = OUT_WIDTH'(np_signed);
            dout_d  = OUT_WIDTH'(nq_signed);
            zerr_d  = 1'b0;
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) job_q <= job_i;
    a_q <= a_d; b_q <= b_d; rem_q <= rem_d; quo_q <= quo_d; dvd_q <= dvd_d;
    np_q <= np_d; nout_q <= nout_d; dout_q <= dout_d; zerr_q <= zerr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(num_out_o)))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && zero_error_o) |-> (num_out_o == '0 && den_out_o == '0))
    else $error("error result not zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GCD) |-> (b_q != '0))
    else $error("gcd divisor zero");

endmodule

`default_nettype wire

>>> rtl/core/rational_multiply_reduce.sv
// ----------------------------------------------------------------------------
// rational_multiply_reduce
// multiplies two signed fractions and reduces the product by its gcd
// ----------------------------------------------------------------------------
// order of work: euclid remainder steps, each a full restoring pass, then the
// two divisions; a request with both products zero goes straight to the result
// throughput: one request at a time in the divider unit; a 2-entry queue lets
// the next requests enter meanwhile
// reset: clears the queue and the back state machine, no payload reset
`default_nettype none

module rational_multiply_reduce import rmr_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // num_a, den_a, num_b, den_b
  input  wire logic [IN_BYTES*8-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // num_out, den_out
  output logic [OUT_BYTES*8-1:0]       m_axis_tdata,
  // zero_error
  output logic                         m_axis_tuser
);

  logic job_valid, job_ready;
  job_t job;
  logic [OUT_WIDTH-1:0] num_out, den_out;

  rmr_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .num_a_i     (s_axis_tdata[DATA_WIDTH-1:0]),
    .den_a_i     (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .num_b_i     (s_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
    .den_b_i     (s_axis_tdata[4*DATA_WIDTH-1:3*DATA_WIDTH]),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  rmr_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i  (job_valid),
    .job_ready_o  (job_ready),
    .job_i        (job),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .num_out_o    (num_out),
    .den_out_o    (den_out),
    .zero_error_o (m_axis_tuser)
  );

  assign m_axis_tdata = {den_out, num_out};

endmodule

`default_nettype wire

>>> tb/rmr_checker.sv
// ----------------------------------------------------------------------------
// rmr_checker
// watches both stream channels of the rational multiply and reduce block,
// predicts the reduced product of every accepted request and compares it
// field by field with the results in order
// ----------------------------------------------------------------------------
`default_nettype none

module rmr_checker import rmr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [IN_BYTES*8-1:0] s_axis_tdata,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [OUT_BYTES*8-1:0] m_axis_tdata,
  input  wire logic                  m_axis_tuser,
  output int                         pending_o,
  output int                         fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] num_out;
    logic [OUT_WIDTH-1:0] den_out;
    logic                 zero_error;
  } ratio_t;

  ratio_t expected_products[$];

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic ratio_t reduce_product(logic [IN_BYTES*8-1:0] req);
    longint            na, da, nb, db, p, q;
    longint unsigned   a, b, t, g, qp, qq;
    ratio_t            r;
    na = longint'($signed(req[DATA_WIDTH-1:0]));
    da = longint'($signed(req[2*DATA_WIDTH-1:DATA_WIDTH]));
    nb = longint'($signed(req[3*DATA_WIDTH-1:2*DATA_WIDTH]));
    db = longint'($signed(req[4*DATA_WIDTH-1:3*DATA_WIDTH]));
    p = na * nb;
    q = da * db;
    a = magnitude(p);
    b = magnitude(q);
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    g = a;
    r = '0;
    if (g == 0) begin
      r.zero_error = 1'b1;
      return r;
    end
    qp = magnitude(p) / g;
    qq = magnitude(q) / g;
    if (p < 0) qp = 64'd0 - qp;
    if (q < 0) qq = 64'd0 - qq;
    r.num_out = qp[OUT_WIDTH-1:0];
    r.den_out = qq[OUT_WIDTH-1:0];
    return r;
  endfunction

  ratio_t got;
  ratio_t want;
  int     mism;

  assign pending_o = expected_products.size();

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      mism = 0;
      if (s_axis_tvalid && s_axis_tready)
        expected_products.push_back(reduce_product(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.num_out    = m_axis_tdata[OUT_WIDTH-1:0];
        got.den_out    = m_axis_tdata[2*OUT_WIDTH-1:OUT_WIDTH];
        got.zero_error = m_axis_tuser;
        if (expected_products.size() == 0) begin
          $display("%0t: unexpected result num %0d den %0d err %0b", $time,
                   $signed(got.num_out), $signed(got.den_out), got.zero_error);
          mism = mism + 1;
        end else begin
          want = expected_products.pop_front();
          if (got.num_out !== want.num_out) begin
            $display("%0t: num_out expected %0d actual %0d", $time,
                     $signed(want.num_out), $signed(got.num_out));
            mism = mism + 1;
          end
          if (got.den_out !== want.den_out) begin
            $display("%0t: den_out expected %0d actual %0d", $time,
                     $signed(want.den_out), $signed(got.den_out));
            mism = mism + 1;
          end
          if (got.zero_error !== want.zero_error) begin
            $display("%0t: zero_error expected %0b actual %0b", $time,
                     want.zero_error, got.zero_error);
            mism = mism + 1;
          end
        end
      end
      fail_count_o <= fail_count_o + mism;
    end
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives directed and random fraction pairs into the rational multiply and
// reduce block with random gaps on both sides and reports the verdict
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import rmr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1000;
  localparam int STALL_LIMIT = 40000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_BYTES*8-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_BYTES*8-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  int                     pending;
  int                     fail_count;
  int                     idle_cycles = 0;
  bit                     no_gaps = 1'b0;

  always #2 clk_i = ~clk_i;

  rational_multiply_reduce DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  rmr_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  task automatic send_fractions(logic [15:0] na, logic [15:0] da,
                                logic [15:0] nb, logic [15:0] db);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {db, nb, da, na};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7)) inside
      0:       return 16'h0000;
      1:       return 16'(signed'($urandom_range(0, 6)) - 3);
      2:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      3, 4:    return 16'(signed'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // result side: random stalls per result, none during burst stretches
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // both products zero
    send_fractions(16'd0, 16'd0, 16'd5, 16'd7);
    send_fractions(16'd3, 16'd4, 16'd0, 16'd0);
    // one product zero
    send_fractions(16'd0, 16'd5, 16'd9, 16'd1);
    send_fractions(16'd3, 16'd0, 16'd1, 16'd2);
    send_fractions(-16'sd6, 16'd0, 16'd4, 16'd1);
    // integer multiplier
    send_fractions(16'd3, 16'd4, 16'd8, 16'd1);
    send_fractions(-16'sd7, 16'd21, 16'd6, 16'd1);
    // extremes
    send_fractions(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_fractions(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_fractions(16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
    send_fractions(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_fractions(16'h7fff, 16'h7ffe, 16'h7ffd, 16'h7fff);
    send_fractions(16'd1, 16'd1, 16'd1, 16'd1);
    // signs
    send_fractions(-16'sd2, 16'd4, 16'd3, -16'sd9);
    send_fractions(16'd12, -16'sd18, 16'd5, 16'd10);
    send_fractions(16'h5555, 16'haaaa, 16'h3333, 16'hcccc);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      no_gaps = (i % 250) >= 200;
      send_fractions(pick_value(), pick_value(), pick_value(), pick_value());
    end
    no_gaps = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (2500) @(posedge clk_i);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
